[design/sd_pkg.sv]
package sd_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int POS_W    = 24;
    localparam int TIME_W   = 32;
    localparam int THR_W    = 52;
    localparam int SQ_W     = 2 * POS_W;
    localparam int DIST_W   = SQ_W + 2;
    localparam int CFG_W    = THR_W;
    localparam int CFG_IDX_W = 2;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [TIME_W-1:0]       stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // control of the shared squared-distance unit
    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic clear;
    } t_sq_ctrl;

endpackage

[design/sd_ram.sv]
module sd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/sd_sqdist.sv]
module sd_sqdist (
    input  logic                              i_clk,
    input  sd_pkg::t_sq_ctrl                  i_ctrl,
    input  logic signed [sd_pkg::POS_W-1:0]   i_a,
    input  logic signed [sd_pkg::POS_W-1:0]   i_b,
    output logic [sd_pkg::DIST_W-1:0]         o_dist
);
    import sd_pkg::*;

    logic signed [POS_W:0]     diff;
    logic signed [2*POS_W+1:0] sq;
    logic [SQ_W-1:0]           r_prod;
    logic [DIST_W-1:0]         r_acc;

    assign diff = $signed({i_a[POS_W-1], i_a}) - $signed({i_b[POS_W-1], i_b});
    assign sq   = diff * diff;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            // square is never negative and stays below 2^48
            r_prod <= sq[SQ_W-1:0];
        end
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_en) begin
            r_acc <= r_acc + DIST_W'(r_prod);
        end
    end

    assign o_dist = r_acc;

endmodule

[design/stillness_detector_core.sv]
// stillness detector core
// input channel (i_valid / o_ready) carries one beat per position sample:
// restart flag, signed 24-bit x/y/z in mm and a wrapping 32-bit ms stamp.
// output channel (o_valid / i_ready) returns one beat per input beat with the
// sticky stopped flag and the queue level after that sample.
// configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user must write it only while the block is idle, not enforced by the block.
// index 0 threshold, 1 still time, 2 sample interval. one sample is handled
// at a time; o_ready is high only when idle. a restart or an already stopped
// sample goes straight to its result; otherwise the queue is scanned from
// the oldest entry, dropping far entries, until one is close or all are
// dropped. each examined entry costs one queue memory read and three passes
// of the single 25x25 squarer plus accumulate and compare.
// throughput: a new sample is taken the cycle after its result is registered.
// a finished result sits in the output register while the receiver stalls;
// the next sample is accepted meanwhile and its result waits behind it.
// reset (synchronous, active low) empties the queue, clears stopped and
// restores the default register values; queue memory needs no clearing.
module stillness_detector_core #(
    parameter int DEPTH = sd_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_restart,
    input  logic signed [sd_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [sd_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [sd_pkg::POS_W-1:0]   i_pos_z,
    input  logic [sd_pkg::TIME_W-1:0]         i_time_ms,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_stopped,
    output logic [$clog2(DEPTH+1)-1:0]        o_queue_level,
    input  logic                              i_cfg_we,
    input  logic [sd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sd_pkg::CFG_W-1:0]          i_cfg_data
);
    import sd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [LW:0]   DEPTH_S = (LW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_THR      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_NEW,
        S_SCAN,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_Z,
        S_SUM,
        S_DECIDE,
        S_DONE
    } t_state;

    t_state r_state;

    logic [THR_W-1:0]  r_thr;
    logic [TIME_W-1:0] r_still;
    logic [TIME_W-1:0] r_interval;

    logic [AW-1:0] r_head;
    logic [LW-1:0] r_fill;
    logic          r_stopped;

    logic signed [POS_W-1:0] r_x, r_y, r_z;
    logic [TIME_W-1:0]       r_time;

    logic          r_out_valid;
    logic          r_out_stopped;
    logic [LW-1:0] r_out_level;

    t_entry        rd_entry;
    t_entry        wr_entry;
    logic [ENTRY_W-1:0] rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    logic [LW:0]   sum_hf;
    logic [LW:0]   sum_newest;
    logic [AW-1:0] tail_addr;
    logic [AW-1:0] newest_addr;
    logic [AW-1:0] head_inc;
    logic          full;
    logic          push;

    t_sq_ctrl                sq_ctrl;
    logic signed [POS_W-1:0] sq_a, sq_b;
    logic [DIST_W-1:0]       sq_sum;
    logic                    far;
    logic [TIME_W-1:0]       age;

    // ring arithmetic without a modulo: sums stay below twice the depth
    assign sum_hf      = (LW + 1)'(r_head) + (LW + 1)'(r_fill);
    assign tail_addr   = (sum_hf >= DEPTH_S) ? AW'(sum_hf - DEPTH_S) : AW'(sum_hf);
    assign sum_newest  = sum_hf - (LW + 1)'(1);
    assign newest_addr = (r_fill == '0) ? r_head :
                         (sum_newest >= DEPTH_S) ? AW'(sum_newest - DEPTH_S) :
                         AW'(sum_newest);
    assign head_inc    = (r_head == LAST_A) ? '0 : r_head + AW'(1);
    assign full        = (r_fill == LW'(DEPTH));

    assign rd_entry = t_entry'(rd_data);
    assign age      = r_time - rd_entry.stamp;

    // first sample always goes in; otherwise only after the sample interval
    assign push    = (r_state == S_CHK_NEW) &&
                     ((r_fill == '0) || (age > r_interval));
    assign wr_en   = push;
    assign wr_addr = full ? r_head : tail_addr;
    assign rd_addr = (r_state == S_IDLE) ? newest_addr : r_head;

    always_comb begin
        wr_entry.x     = r_x;
        wr_entry.y     = r_y;
        wr_entry.z     = r_z;
        wr_entry.stamp = r_time;
    end

    sd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_entry),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        sq_ctrl = '0;
        sq_a    = r_x;
        sq_b    = rd_entry.x;
        unique case (r_state)
            S_SQ_X: begin
                sq_ctrl.mul_en = 1'b1;
                sq_ctrl.clear  = 1'b1;
            end
            S_SQ_Y: begin
                sq_ctrl.mul_en = 1'b1;
                sq_ctrl.acc_en = 1'b1;
                sq_a = r_y;
                sq_b = rd_entry.y;
            end
            S_SQ_Z: begin
                sq_ctrl.mul_en = 1'b1;
                sq_ctrl.acc_en = 1'b1;
                sq_a = r_z;
                sq_b = rd_entry.z;
            end
            S_SUM: begin
                sq_ctrl.acc_en = 1'b1;
            end
            default: begin
                sq_ctrl = '0;
            end
        endcase
    end

    sd_sqdist u_sqdist (
        .i_clk  (i_clk),
        .i_ctrl (sq_ctrl),
        .i_a    (sq_a),
        .i_b    (sq_b),
        .o_dist (sq_sum)
    );

    assign far = (THR_W'(sq_sum) > r_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= THR_W'(10000);
            r_still     <= TIME_W'(5000);
            r_interval  <= TIME_W'(500);
            r_head      <= '0;
            r_fill      <= '0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_THR:      r_thr      <= i_cfg_data;
                    CFG_STILL:    r_still    <= i_cfg_data[TIME_W-1:0];
                    CFG_INTERVAL: r_interval <= i_cfg_data[TIME_W-1:0];
                    default:      ;
                endcase
            end

            if ((r_state == S_DONE) && (!r_out_valid || i_ready)) begin
                r_out_valid   <= 1'b1;
                r_out_stopped <= r_stopped;
                r_out_level   <= r_fill;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_x    <= i_pos_x;
                        r_y    <= i_pos_y;
                        r_z    <= i_pos_z;
                        r_time <= i_time_ms;
                        if (i_restart) begin
                            r_head    <= '0;
                            r_fill    <= '0;
                            r_stopped <= 1'b0;
                            r_state   <= S_DONE;
                        end else if (r_stopped) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_CHK_NEW;
                        end
                    end
                end
                S_CHK_NEW: begin
                    if (push) begin
                        if (full) begin
                            r_head <= head_inc;
                        end else begin
                            r_fill <= r_fill + LW'(1);
                        end
                    end
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_state <= (r_fill == '0) ? S_DONE : S_SQ_X;
                end
                S_SQ_X: r_state <= S_SQ_Y;
                S_SQ_Y: r_state <= S_SQ_Z;
                S_SQ_Z: r_state <= S_SUM;
                S_SUM:  r_state <= S_DECIDE;
                S_DECIDE: begin
                    if (far) begin
                        r_head  <= head_inc;
                        r_fill  <= r_fill - LW'(1);
                        r_state <= S_SCAN;
                    end else begin
                        if (age > r_still) begin
                            r_stopped <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_stopped     = r_out_stopped;
    assign o_queue_level = r_out_level;

endmodule

[test/sd_tb_pkg.sv]
package sd_tb_pkg;

    typedef enum logic [sd_pkg::CFG_IDX_W-1:0] {
        REG_MOVE_THR   = 2'd0,
        REG_STILL_TIME = 2'd1,
        REG_SAMPLE_IVL = 2'd2,
        REG_SPARE      = 2'd3
    } t_cfg_reg;

    localparam logic [sd_pkg::CFG_W-1:0] MOVE_THR_RESET   = sd_pkg::CFG_W'(10000);
    localparam logic [sd_pkg::CFG_W-1:0] STILL_TIME_RESET = sd_pkg::CFG_W'(5000);
    localparam logic [sd_pkg::CFG_W-1:0] SAMPLE_IVL_RESET = sd_pkg::CFG_W'(500);

endpackage

[test/sd_status_checker.sv]
module sd_status_checker #(
    parameter int DEPTH = sd_pkg::DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic                            i_restart,
    input  logic signed [sd_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [sd_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [sd_pkg::POS_W-1:0] i_pos_z,
    input  logic [sd_pkg::TIME_W-1:0]       i_time_ms,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_stopped,
    input  logic [$clog2(DEPTH+1)-1:0]      i_queue_level,
    input  logic                            i_cfg_we,
    input  logic [sd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sd_pkg::CFG_W-1:0]        i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import sd_pkg::*;
    import sd_tb_pkg::*;

    localparam int LVL_W     = $clog2(DEPTH + 1);
    localparam int EXP_DEPTH = 8;

    typedef struct packed {
        logic             stopped;
        logic [LVL_W-1:0] level;
    } t_status;

    logic [THR_W-1:0]        thr_sq;
    logic [TIME_W-1:0]       still_ms;
    logic [TIME_W-1:0]       ivl_ms;
    logic signed [POS_W-1:0] x_mem [DEPTH];
    logic signed [POS_W-1:0] y_mem [DEPTH];
    logic signed [POS_W-1:0] z_mem [DEPTH];
    logic [TIME_W-1:0]       stamp_mem [DEPTH];
    int                      head;
    int                      fill;
    logic                    stopped;
    t_status                 exp_buf [EXP_DEPTH];
    int                      exp_rd  = 0;
    int                      exp_wr  = 0;
    int                      exp_cnt = 0;
    int                      fails = 0;

    // full queue drops its oldest entry to make room
    task automatic record_sample(input logic signed [POS_W-1:0] px, py, pz,
                                 input logic [TIME_W-1:0] now);
        int slot;
        if (fill >= DEPTH) begin
            slot = head;
            head = (head + 1) % DEPTH;
        end else begin
            slot = (head + fill) % DEPTH;
            fill++;
        end
        x_mem[slot]     = px;
        y_mem[slot]     = py;
        z_mem[slot]     = pz;
        stamp_mem[slot] = now;
    endtask

    task automatic track_sample(input logic rs, input logic signed [POS_W-1:0] px, py, pz,
                                input logic [TIME_W-1:0] now, output t_status st);
        int              newest;
        longint          dx;
        longint          dy;
        longint          dz;
        logic [63:0]     dist_sq;
        logic [TIME_W-1:0] age;
        if (rs) begin
            head    = 0;
            fill    = 0;
            stopped = 1'b0;
        end else if (!stopped) begin
            if (fill == 0)
                record_sample(px, py, pz, now);
            newest = (head + fill - 1) % DEPTH;
            age    = now - stamp_mem[newest];
            if (age > ivl_ms)
                record_sample(px, py, pz, now);
            // walk from the oldest entry until one is close enough
            while (fill > 0) begin
                dx      = longint'(px) - longint'(x_mem[head]);
                dy      = longint'(py) - longint'(y_mem[head]);
                dz      = longint'(pz) - longint'(z_mem[head]);
                dist_sq = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
                if (dist_sq > 64'(thr_sq)) begin
                    head = (head + 1) % DEPTH;
                    fill--;
                end else begin
                    age = now - stamp_mem[head];
                    if (age > still_ms)
                        stopped = 1'b1;
                    break;
                end
            end
        end
        st.stopped = stopped;
        st.level   = fill[LVL_W-1:0];
    endtask

    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        t_status predicted;
        if (!i_rst_n) begin
            thr_sq   = MOVE_THR_RESET;
            still_ms = STILL_TIME_RESET[TIME_W-1:0];
            ivl_ms   = SAMPLE_IVL_RESET[TIME_W-1:0];
            head     = 0;
            fill     = 0;
            stopped  = 1'b0;
            exp_rd   = 0;
            exp_wr   = 0;
            exp_cnt  = 0;
        end else begin
            // result beat first: it can never belong to a sample taken on this edge
            if (i_out_valid && i_out_ready) begin
                got.stopped = i_stopped;
                got.level   = i_queue_level;
                if (exp_cnt == 0) begin
                    fails++;
                    $error("result beat with none outstanding: stopped %0d, queue_level %0d",
                           got.stopped, got.level);
                end else begin
                    want    = exp_buf[exp_rd];
                    exp_rd  = (exp_rd + 1) % EXP_DEPTH;
                    exp_cnt--;
                    if (got.stopped !== want.stopped) begin
                        fails++;
                        $error("stopped: expected %0d, got %0d", want.stopped, got.stopped);
                    end
                    if (got.level !== want.level) begin
                        fails++;
                        $error("queue_level: expected %0d, got %0d", want.level, got.level);
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_MOVE_THR:   thr_sq   = i_cfg_data[THR_W-1:0];
                    REG_STILL_TIME: still_ms = i_cfg_data[TIME_W-1:0];
                    REG_SAMPLE_IVL: ivl_ms   = i_cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                track_sample(i_restart, i_pos_x, i_pos_y, i_pos_z, i_time_ms, predicted);
                if (exp_cnt == EXP_DEPTH) begin
                    fails++;
                    $error("more than %0d results outstanding", EXP_DEPTH);
                end else begin
                    exp_buf[exp_wr] = predicted;
                    exp_wr          = (exp_wr + 1) % EXP_DEPTH;
                    exp_cnt++;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= exp_cnt;
    end

endmodule

[test/tb_stillness_detector_core.sv]
module tb_stillness_detector_core;
    import sd_pkg::*;
    import sd_tb_pkg::*;

    localparam int LVL_W          = $clog2(DEPTH_DEF + 1);
    localparam int POS_MAX        = 8388607;
    localparam int POS_MIN        = -8388608;
    localparam int N_PHASES       = 8;
    localparam int PHASE_ITEMS    = 172;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 2 * (3 + 6 * (DEPTH_DEF + 1));
    localparam int WATCHDOG_LIMIT = 4000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic                    i_restart;
    logic signed [POS_W-1:0] i_pos_x;
    logic signed [POS_W-1:0] i_pos_y;
    logic signed [POS_W-1:0] i_pos_z;
    logic [TIME_W-1:0]       i_time_ms;
    logic                    o_valid;
    logic                    i_ready;
    logic                    o_stopped;
    logic [LVL_W-1:0]        o_queue_level;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_W-1:0]        i_cfg_data;

    int fail_count;
    int pending_cnt;
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int hold_reqs    = 0;
    int holds_done   = 0;
    int quiet_cycles = 0;

    stillness_detector_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_restart     (i_restart),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_time_ms     (i_time_ms),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_stopped     (o_stopped),
        .o_queue_level (o_queue_level),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    sd_status_checker #(.DEPTH(DEPTH_DEF)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_restart     (i_restart),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_time_ms     (i_time_ms),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_stopped     (o_stopped),
        .i_queue_level (o_queue_level),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != holds_done) begin
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("stillness_detector_core test failed");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic rs, input int px, py, pz, input logic [31:0] ts);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_restart <= rs;
        i_pos_x   <= px[POS_W-1:0];
        i_pos_y   <= py[POS_W-1:0];
        i_pos_z   <= pz[POS_W-1:0];
        i_time_ms <= ts;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_cnt != 0);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    function automatic int near(input int centre, input int amp);
        int v;
        v = centre + int'($urandom_range(0, 2 * amp)) - amp;
        if (v > POS_MAX)
            v = POS_MAX;
        else if (v < POS_MIN)
            v = POS_MIN;
        return v;
    endfunction

    initial begin
        int          roll;
        int          amp;
        int          step_max;
        int          jitter;
        int          base_x;
        int          base_y;
        int          base_z;
        logic [31:0] t_now;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_restart   <= 1'b0;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        i_pos_z     <= '0;
        i_time_ms   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_MOVE_THR;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats on the reset settings
        send_sample(1'b0, POS_MAX, POS_MAX, POS_MAX, 32'd0);
        send_sample(1'b0, POS_MAX, POS_MAX, POS_MAX, 32'd500);   // age equals interval
        send_sample(1'b0, POS_MAX, POS_MAX, POS_MAX, 32'd501);
        send_sample(1'b0, POS_MIN, POS_MIN, POS_MIN, 32'd600);   // drops empty the queue
        send_sample(1'b0, POS_MIN, POS_MIN, POS_MIN, 32'd650);
        send_sample(1'b1, POS_MAX, POS_MIN, POS_MAX, 32'hFFFF_FFFF);
        send_sample(1'b0, 0, 0, 0, 32'hFFFF_FF00);
        send_sample(1'b0, 100, 0, 0, 32'h0000_00F4);              // distance on threshold
        send_sample(1'b0, 100, 1, 0, 32'h0000_00F5);              // just past it, time wraps
        for (int k = 1; k <= 8; k++)
            send_sample(1'b0, 100, 1, 0, 32'hF5 + 600 * k);
        send_sample(1'b0, 100, 1, 0, 32'hF5 + 5000);              // held exactly still time
        send_sample(1'b0, 100, 1, 0, 32'hF5 + 5001);
        send_sample(1'b0, POS_MIN, POS_MAX, 0, 32'hF5 + 9000);    // already stopped
        send_sample(1'b1, 0, 0, 0, 32'd0);
        send_sample(1'b0, POS_MIN, POS_MAX, POS_MIN, 32'h8000_0000);
        send_sample(1'b1, POS_MAX, POS_MAX, POS_MAX, 32'h8000_0000);

        base_x = 0;
        base_y = 0;
        base_z = 0;
        t_now  = $urandom;
        step_max = 400;
        jitter   = 30;
        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            case (p % 4)
                0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_gap_pct = 53; rx_stall_pct = 0;  end
                2: begin tx_gap_pct = 0;  rx_stall_pct = 53; end
                default: begin tx_gap_pct = 35; rx_stall_pct = 35; end
            endcase
            case (p)
                1: begin
                    write_reg(REG_MOVE_THR, {CFG_W{1'b1}});
                    write_reg(REG_STILL_TIME, {CFG_W{1'b1}});
                    write_reg(REG_SAMPLE_IVL, {CFG_W{1'b1}});
                    step_max = 100000;
                    jitter   = 4000000;
                end
                2: begin
                    write_reg(REG_MOVE_THR, '0);
                    write_reg(REG_STILL_TIME, '0);
                    write_reg(REG_SAMPLE_IVL, '0);
                    step_max = 3;
                    jitter   = 1;
                end
                3: begin
                    // long still time and short interval so the queue wraps
                    write_reg(REG_MOVE_THR, CFG_W'(1000000));
                    write_reg(REG_STILL_TIME, CFG_W'(30000));
                    write_reg(REG_SAMPLE_IVL, CFG_W'(100));
                    write_reg(REG_SPARE, CFG_W'({$urandom, $urandom}));
                    step_max = 300;
                    jitter   = 300;
                end
                4: begin
                    write_reg(REG_MOVE_THR, CFG_W'($urandom_range(0, 1 << 20)));
                    write_reg(REG_STILL_TIME, CFG_W'($urandom_range(0, 8000)));
                    write_reg(REG_SAMPLE_IVL, CFG_W'($urandom_range(0, 1000)));
                    step_max = 1000;
                    jitter   = 600;
                end
                5: begin
                    write_reg(REG_MOVE_THR, CFG_W'(40000));
                    write_reg(REG_STILL_TIME, CFG_W'(2000));
                    write_reg(REG_SAMPLE_IVL, CFG_W'(1));
                    step_max = 200;
                    jitter   = 100;
                end
                6: begin
                    // upper data bits are junk for the 32-bit registers
                    write_reg(REG_MOVE_THR, CFG_W'({$urandom, $urandom}));
                    write_reg(REG_STILL_TIME, CFG_W'({$urandom, $urandom}));
                    write_reg(REG_SAMPLE_IVL, CFG_W'({$urandom, $urandom}));
                    step_max = $urandom_range(1, 100000);
                    jitter   = 1000;
                end
                7: begin
                    write_reg(REG_MOVE_THR, MOVE_THR_RESET);
                    write_reg(REG_STILL_TIME, STILL_TIME_RESET);
                    write_reg(REG_SAMPLE_IVL, SAMPLE_IVL_RESET);
                    step_max = 400;
                    jitter   = 30;
                end
                default: ;
            endcase
            i_cfg_we <= 1'b0;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == PHASE_ITEMS / 2)
                    hold_reqs++;
                if (p == 4 && n == PHASE_ITEMS / 2)
                    wait_drained();
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    send_sample(1'b1, $urandom, $urandom, $urandom, $urandom);
                    if ($urandom_range(0, 9) == 0)
                        t_now = 32'hFFFF_FFFF - $urandom_range(0, 20000);
                end else if (roll < 8) begin
                    send_sample(1'b0, $urandom, $urandom, $urandom, $urandom);
                end else begin
                    if ($urandom_range(0, 99) < 6) begin
                        if ($urandom_range(0, 3) == 0) begin
                            base_x = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
                            base_y = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
                            base_z = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
                        end else begin
                            base_x = int'($urandom_range(0, 16000000)) - 8000000;
                            base_y = int'($urandom_range(0, 16000000)) - 8000000;
                            base_z = int'($urandom_range(0, 16000000)) - 8000000;
                        end
                    end
                    t_now += $urandom_range(0, step_max);
                    amp = $urandom_range(0, jitter);
                    send_sample(1'b0, near(base_x, amp), near(base_y, amp),
                                near(base_z, amp), t_now);
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("stillness_detector_core test passed");
        else
            $display("stillness_detector_core test failed");
        $finish;
    end

endmodule

[files.f]
design/sd_pkg.sv
design/sd_ram.sv
design/sd_sqdist.sv
design/stillness_detector_core.sv
test/sd_tb_pkg.sv
test/sd_status_checker.sv
test/tb_stillness_detector_core.sv
